// ----- hw/rtl/lr_pkg.sv -----
// shared types and constants for the line rasterizer
package lr_pkg;

    localparam int COORD_BITS  = 6;
    localparam int SYMBOL_BITS = 8;
    localparam int ERR_W       = COORD_BITS + 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_BITS-1:0]  t_coord;
    typedef logic [SYMBOL_BITS-1:0] t_symbol;
    typedef logic signed [ERR_W-1:0] t_err;

    typedef struct packed {
        t_coord  x_start;
        t_coord  y_start;
        t_coord  x_end;
        t_coord  y_end;
        t_coord  delta_x;
        t_coord  delta_y;
        logic    step_x_neg;
        logic    step_y_neg;
        t_err    err_init;
        t_symbol symbol;
    } t_cmd;

endpackage

// ----- hw/rtl/lr_front.sv -----
// front end: takes line commands and works out deltas, step directions and starting error
module lr_front
    import lr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_coord  i_x_start,
    input  t_coord  i_y_start,
    input  t_coord  i_x_end,
    input  t_coord  i_y_end,
    input  t_symbol i_symbol,
    output logic    o_cmd_valid,
    input  logic    i_cmd_ready,
    output t_cmd    o_cmd
);

    logic r_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    always_comb begin
        n_cmd            = '0;
        n_cmd.x_start    = i_x_start;
        n_cmd.y_start    = i_y_start;
        n_cmd.x_end      = i_x_end;
        n_cmd.y_end      = i_y_end;
        n_cmd.symbol     = i_symbol;
        n_cmd.delta_x    = (i_x_start > i_x_end) ? i_x_start - i_x_end : i_x_end - i_x_start;
        n_cmd.delta_y    = (i_y_start > i_y_end) ? i_y_start - i_y_end : i_y_end - i_y_start;
        n_cmd.step_x_neg = !(i_x_start < i_x_end);
        n_cmd.step_y_neg = !(i_y_start < i_y_end);
        n_cmd.err_init   = $signed({{(ERR_W-COORD_BITS){1'b0}}, n_cmd.delta_x})
                         - $signed({{(ERR_W-COORD_BITS){1'b0}}, n_cmd.delta_y});
    end

    assign o_ready     = !r_vld || i_cmd_ready;
    assign accept      = i_valid && o_ready;
    assign o_cmd_valid = r_vld;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_cmd_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !i_cmd_ready |=> r_vld && $stable(r_cmd))
        else $error("front: pending command changed while stalled");

endmodule

// ----- hw/rtl/lr_queue.sv -----
// short command queue between front and back ends
module lr_queue
    import lr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [QPTR_W-1:0] f_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= f_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= f_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue: fill count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QUEUE_DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue: pointers disagree with fill count");

endmodule

// ----- hw/rtl/lr_back.sv -----
// back end: steps through the line one pixel per cycle, while the output is not stalled, into an output register
module lr_back
    import lr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    output logic    o_cmd_ready,
    input  t_cmd    i_cmd,
    output logic    o_valid,
    input  logic    i_ready,
    output t_coord  o_pixel_x,
    output t_coord  o_pixel_y,
    output t_symbol o_pixel_symbol,
    output logic    o_last_pixel
);

    logic    r_busy;
    t_coord  r_cur_x, r_cur_y, r_tgt_x, r_tgt_y, r_dx, r_dy;
    logic    r_sxn, r_syn;
    t_err    r_err;
    t_symbol r_sym;
    logic    r_out_vld;
    t_coord  r_out_x, r_out_y;
    t_symbol r_out_sym;
    logic    r_out_last;

    logic    emit, at_end, load, step_x, step_y;
    t_err    e2, dx_s, dy_s, n_err;
    t_coord  n_cur_x, n_cur_y;

    assign at_end      = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);
    assign emit        = r_busy && (!r_out_vld || i_ready);
    assign o_cmd_ready = !r_busy;
    assign load        = i_cmd_valid && !r_busy;

    always_comb begin
        dx_s    = $signed({{(ERR_W-COORD_BITS){1'b0}}, r_dx});
        dy_s    = $signed({{(ERR_W-COORD_BITS){1'b0}}, r_dy});
        e2      = r_err <<< 1;
        step_x  = (e2 > -dy_s);
        step_y  = (e2 < dx_s);
        n_err   = r_err - (step_x ? dy_s : t_err'(0)) + (step_y ? dx_s : t_err'(0));
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (step_x) begin
            n_cur_x = r_sxn ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
        end
        if (step_y) begin
            n_cur_y = r_syn ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && at_end) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur_x <= i_cmd.x_start;
            r_cur_y <= i_cmd.y_start;
            r_tgt_x <= i_cmd.x_end;
            r_tgt_y <= i_cmd.y_end;
            r_dx    <= i_cmd.delta_x;
            r_dy    <= i_cmd.delta_y;
            r_sxn   <= i_cmd.step_x_neg;
            r_syn   <= i_cmd.step_y_neg;
            r_err   <= i_cmd.err_init;
            r_sym   <= i_cmd.symbol;
        end else if (emit && !at_end) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_err   <= n_err;
        end
        if (emit) begin
            r_out_x    <= r_cur_x;
            r_out_y    <= r_cur_y;
            r_out_sym  <= r_sym;
            r_out_last <= at_end;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_y      = r_out_y;
    assign o_pixel_symbol = r_out_sym;
    assign o_last_pixel   = r_out_last;

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && at_end |=> !r_busy && o_last_pixel)
        else $error("back: end point beat did not close the line");

    a_mid_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && !at_end |=> r_busy && !o_last_pixel)
        else $error("back: line stopped before its end point");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_cmd_ready)
        else $error("back: command taken while a line is in progress");

endmodule

// ----- hw/rtl/line_rasterizer_top.sv -----
// Bresenham line rasterizer: one command in, one beat per pixel out, last beat marked at the end point.
// A command of deltas dx and dy yields max(dx, dy) + 1 output beats, one per cycle from the
// stepping unit in the back end while the output is not stalled; the unit is loaded between
// commands while idle. The front end register and a two-entry command queue take further
// commands while a line is being drawn.
module line_rasterizer_top
    import lr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_coord  i_x_start,
    input  t_coord  i_y_start,
    input  t_coord  i_x_end,
    input  t_coord  i_y_end,
    input  t_symbol i_symbol,
    output logic    o_valid,
    input  logic    i_ready,
    output t_coord  o_pixel_x,
    output t_coord  o_pixel_y,
    output t_symbol o_pixel_symbol,
    output logic    o_last_pixel
);

    logic f_vld, f_rdy, q_vld, q_rdy;
    t_cmd f_cmd, q_cmd;

    lr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .i_symbol    (i_symbol),
        .o_cmd_valid (f_vld),
        .i_cmd_ready (f_rdy),
        .o_cmd       (f_cmd)
    );

    lr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_vld),
        .o_push_ready (f_rdy),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_vld),
        .i_pop_ready  (q_rdy),
        .o_pop_cmd    (q_cmd)
    );

    lr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_vld),
        .o_cmd_ready    (q_rdy),
        .i_cmd          (q_cmd),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_symbol (o_pixel_symbol),
        .o_last_pixel   (o_last_pixel)
    );

endmodule

// ----- verif/lr_checker.sv -----
`timescale 1ns / 100ps
// checker for the line rasterizer: predicts pixel beats from accepted commands and compares them
module lr_checker
    import lr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  logic    i_cmd_ready,
    input  t_coord  i_x_start,
    input  t_coord  i_y_start,
    input  t_coord  i_x_end,
    input  t_coord  i_y_end,
    input  t_symbol i_symbol,
    input  logic    i_pix_valid,
    input  logic    i_pix_ready,
    input  t_coord  i_pixel_x,
    input  t_coord  i_pixel_y,
    input  t_symbol i_pixel_symbol,
    input  logic    i_last_pixel,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_lines,
    output int      o_pixels
);

    typedef struct packed {
        t_coord  x;
        t_coord  y;
        t_symbol sym;
        logic    last;
    } t_pixel_exp;

    t_pixel_exp expected_pixels[$];
    int         fail_count = 0;
    int         line_count = 0;
    int         pixel_count = 0;

    task automatic report_mismatch(input string msg);
        if (fail_count < 50)
            $display("ERROR at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // bresenham walk, symmetric error form for all octants
    function automatic void plot_line(input t_coord xs, input t_coord ys, input t_coord xe,
                                      input t_coord ye, input t_symbol sym);
        int         dx;
        int         dy;
        int         err;
        int         e2;
        int         cx;
        int         cy;
        logic       x_neg;
        logic       y_neg;
        bit         done;
        t_pixel_exp px;
        dx    = (xs > xe) ? int'(xs) - int'(xe) : int'(xe) - int'(xs);
        dy    = (ys > ye) ? int'(ys) - int'(ye) : int'(ye) - int'(ys);
        x_neg = !(xs < xe);
        y_neg = !(ys < ye);
        err   = dx - dy;
        cx    = int'(xs);
        cy    = int'(ys);
        done  = 1'b0;
        while (!done) begin
            done    = (cx == int'(xe)) && (cy == int'(ye));
            px.x    = t_coord'(cx);
            px.y    = t_coord'(cy);
            px.sym  = sym;
            px.last = done;
            expected_pixels.push_back(px);
            if (!done) begin
                e2 = 2 * err;
                if (e2 > -dy) begin
                    err -= dy;
                    cx = x_neg ? cx - 1 : cx + 1;
                end
                if (e2 < dx) begin
                    err += dx;
                    cy = y_neg ? cy - 1 : cy + 1;
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_pixel_exp want;
        if (i_rst_n) begin
            if (i_pix_valid && i_pix_ready) begin
                pixel_count++;
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel beat (%0d,%0d)",
                                              i_pixel_x, i_pixel_y));
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel_x !== want.x)
                        report_mismatch($sformatf("pixel_x got %0d want %0d",
                                                  i_pixel_x, want.x));
                    if (i_pixel_y !== want.y)
                        report_mismatch($sformatf("pixel_y got %0d want %0d",
                                                  i_pixel_y, want.y));
                    if (i_pixel_symbol !== want.sym)
                        report_mismatch($sformatf("pixel_symbol got %02h want %02h",
                                                  i_pixel_symbol, want.sym));
                    if (i_last_pixel !== want.last)
                        report_mismatch($sformatf("last_pixel got %b want %b at (%0d,%0d)",
                                                  i_last_pixel, want.last, want.x, want.y));
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                line_count++;
                plot_line(i_x_start, i_y_start, i_x_end, i_y_end, i_symbol);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_pixels.size();
        o_lines      <= line_count;
        o_pixels     <= pixel_count;
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// testbench top for the line rasterizer: clock, reset, command stimulus, output back-pressure
module tb;
    import lr_pkg::*;

    localparam int N_RANDOM   = 288;
    localparam int N_CALM     = 60;
    localparam int LONG_HOLD  = 400;
    localparam int DRAIN_WAIT = 80;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_ready;
    t_coord  i_x_start;
    t_coord  i_y_start;
    t_coord  i_x_end;
    t_coord  i_y_end;
    t_symbol i_symbol;
    logic    o_valid;
    logic    i_ready;
    t_coord  o_pixel_x;
    t_coord  o_pixel_y;
    t_symbol o_pixel_symbol;
    logic    o_last_pixel;

    int fail_count;
    int pending;
    int lines_seen;
    int pixels_seen;

    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    line_rasterizer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_symbol       (i_symbol),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_symbol (o_pixel_symbol),
        .o_last_pixel   (o_last_pixel)
    );

    lr_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (i_valid),
        .i_cmd_ready    (o_ready),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_symbol       (i_symbol),
        .i_pix_valid    (o_valid),
        .i_pix_ready    (i_ready),
        .i_pixel_x      (o_pixel_x),
        .i_pixel_y      (o_pixel_y),
        .i_pixel_symbol (o_pixel_symbol),
        .i_last_pixel   (o_last_pixel),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_lines        (lines_seen),
        .o_pixels       (pixels_seen)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // output side: random stall bursts, one long hold-off on request
    initial begin
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    task automatic send_line(input t_coord xs, input t_coord ys, input t_coord xe,
                             input t_coord ye, input t_symbol sym, input bit may_idle);
        i_valid   <= 1'b1;
        i_x_start <= xs;
        i_y_start <= ys;
        i_x_end   <= xe;
        i_y_end   <= ye;
        i_symbol  <= sym;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (may_idle && !calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    function automatic t_coord near(input int c);
        int v;
        v = c + int'($urandom_range(0, 8)) - 4;
        if (v < 0)
            v = 0;
        if (v > 63)
            v = 63;
        return t_coord'(v);
    endfunction

    initial begin
        int     kind;
        int     waited;
        t_coord xs;
        t_coord ys;
        t_coord xe;
        t_coord ye;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_x_start = '0;
        i_y_start = '0;
        i_x_end   = '0;
        i_y_end   = '0;
        i_symbol  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero-length, full-canvas axes and diagonals, every octant
        send_line(6'd0, 6'd0, 6'd0, 6'd0, 8'h00, 1'b1);
        send_line(6'd63, 6'd63, 6'd63, 6'd63, 8'hff, 1'b1);
        send_line(6'd0, 6'd0, 6'd63, 6'd0, 8'haa, 1'b1);
        send_line(6'd63, 6'd63, 6'd0, 6'd63, 8'h55, 1'b1);
        send_line(6'd0, 6'd0, 6'd0, 6'd63, 8'h01, 1'b1);
        send_line(6'd63, 6'd63, 6'd63, 6'd0, 8'h80, 1'b1);
        send_line(6'd0, 6'd0, 6'd63, 6'd63, 8'hff, 1'b1);
        send_line(6'd63, 6'd63, 6'd0, 6'd0, 8'h00, 1'b1);
        send_line(6'd63, 6'd0, 6'd0, 6'd63, 8'h7e, 1'b1);
        send_line(6'd0, 6'd63, 6'd63, 6'd0, 8'h81, 1'b1);
        send_line(6'd10, 6'd20, 6'd50, 6'd30, 8'h11, 1'b1);
        send_line(6'd50, 6'd30, 6'd10, 6'd20, 8'h22, 1'b1);
        send_line(6'd20, 6'd10, 6'd30, 6'd50, 8'h33, 1'b1);
        send_line(6'd30, 6'd50, 6'd20, 6'd10, 8'h44, 1'b1);
        send_line(6'd10, 6'd50, 6'd55, 6'd40, 8'h66, 1'b1);
        send_line(6'd55, 6'd40, 6'd10, 6'd50, 8'h77, 1'b1);
        send_line(6'd40, 6'd5, 6'd30, 6'd60, 8'h88, 1'b1);
        send_line(6'd30, 6'd60, 6'd40, 6'd5, 8'h99, 1'b1);
        send_line(6'd5, 6'd5, 6'd6, 6'd6, 8'hcc, 1'b1);
        send_line(6'd6, 6'd5, 6'd5, 6'd6, 8'hdd, 1'b1);
        send_line(6'd0, 6'd1, 6'd63, 6'd0, 8'hee, 1'b1);
        send_line(6'd1, 6'd63, 6'd0, 6'd0, 8'h0f, 1'b1);
        send_line(6'd32, 6'd31, 6'd31, 6'd32, 8'hf0, 1'b1);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 100)
                hold_req = 1'b1;
            if (n == N_RANDOM - N_CALM) begin
                waited = 0;
                while (!hold_done && waited < 2000) begin
                    @(posedge i_clk);
                    waited++;
                end
                calm = 1'b1;
            end
            kind = $urandom_range(0, 9);
            xs = t_coord'($urandom_range(0, 63));
            ys = t_coord'($urandom_range(0, 63));
            xe = t_coord'($urandom_range(0, 63));
            ye = t_coord'($urandom_range(0, 63));
            case (kind)
                0, 1: begin
                    xe = near(int'(xs));
                    ye = near(int'(ys));
                end
                2: ye = ys;
                3: xe = xs;
                4: begin
                    xs = ($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0;
                    ys = ($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0;
                    xe = ($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0;
                    ye = ($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0;
                end
                default: ;
            endcase
            send_line(xs, ys, xe, ye, t_symbol'($urandom_range(0, 255)),
                      !(n >= 100 && n < 114));
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Drew %0d line commands as %0d pixel beats: all octants, zero-length,",
                 lines_seen, pixels_seen);
        $display("axis-aligned and full-canvas lines, random stalls and a long output hold-off.");
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
